>>> hdl/lcm_pkg.sv
package lcm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int WEIGHT_W  = 48;
  localparam int STRAT_W   = 3;

  // quotient of 2^(2*FRAC_BITS) by a divisor of up to five times a data word
  localparam int QUOT_W = 2 * FRAC_BITS + 1;
  localparam int DIV_W  = DATA_W + 3;

  localparam int IN_TDATA_W  = ((3 * DATA_W + 3 * FRAC_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((WEIGHT_W + 7) / 8) * 8;

  // floor(y / 5) = (y * MAG5) >> MAG_SHIFT for any 32-bit y
  localparam logic [31:0] MAG5      = 32'hCCCC_CCCD;
  localparam int          MAG_SHIFT = 34;

  localparam logic [FRAC_W-1:0]   ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [WEIGHT_W-1:0] WMAX  = '1;

  typedef enum logic [STRAT_W-1:0] {
    STRAT_UNIFORM   = 3'd0,
    STRAT_LATENCY   = 3'd1,
    STRAT_BALANCED  = 3'd2,
    STRAT_BANDWIDTH = 3'd3,
    STRAT_COST      = 3'd4,
    STRAT_ADAPTIVE  = 3'd5
  } strategy_e;

  typedef enum logic [2:0] {
    MODE_UNIFORM,
    MODE_LATENCY,
    MODE_COST,
    MODE_INVBW,
    MODE_BALANCED,
    MODE_RELIAB
  } mode_e;

  typedef struct packed {
    logic [WEIGHT_W-1:0] base;
    logic                add_quo;
    logic                div_zero;
  } div_side_t;

endpackage

>>> hdl/link_cost_metric.sv
// Link cost metric: routing weight of one link per transaction.
// Slave stream carries a link record (latency, bandwidth, utilization,
// packet loss, cost, reliability); master stream returns its weight in
// unsigned Q32.16, with tuser set when the weight saturated (zero divisor).
// The strategy register is written through cfg_we_i/cfg_wdata_i; the user
// must write it only while the pipe is empty, which the block does not
// enforce; reset selects the latency strategy. Pipeline: 4 front stages,
// 33 divider stages, output register. Throughput: one transaction per
// cycle while the master side accepts; the 33-stage restoring divider for
// ONE*ONE/divisor and the front multipliers are fully pipelined.
// Reset clears all valid bits; results in flight are dropped.
// When the master side stalls with a result pending, the whole pipe holds
// and s_axis_tready drops; no transaction is lost or repeated.
module link_cost_metric
  import lcm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [STRAT_W-1:0]     cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // latency, bandwidth, utilization, loss, link_cost, reliability
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // weight
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // saturated
  output logic [0:0]             m_axis_tuser
);

  localparam int LAT_LO  = 0;
  localparam int BW_LO   = DATA_W;
  localparam int UTIL_LO = 2 * DATA_W;
  localparam int LOSS_LO = 2 * DATA_W + FRAC_W;
  localparam int COST_LO = 2 * DATA_W + 2 * FRAC_W;
  localparam int REL_LO  = 3 * DATA_W + 2 * FRAC_W;

  logic [STRAT_W-1:0]  strat_q;
  logic                en;

  logic                fr_valid;
  logic [DIV_W-1:0]    fr_divisor;
  div_side_t           fr_side;

  logic                dv_valid;
  logic [QUOT_W-1:0]   dv_quo;
  div_side_t           dv_side;

  logic                out_v_q;
  logic [WEIGHT_W-1:0] weight_q, weight_d;
  logic                sat_q, sat_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strat_q <= STRAT_LATENCY;
    end else if (cfg_we_i) begin
      strat_q <= cfg_wdata_i;
    end
  end

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  lcm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (s_axis_tvalid),
    .strat_i       (strat_q),
    .latency_i     (s_axis_tdata[LAT_LO +: DATA_W]),
    .bandwidth_i   (s_axis_tdata[BW_LO +: DATA_W]),
    .utilization_i (s_axis_tdata[UTIL_LO +: FRAC_W]),
    .loss_frac_i   (s_axis_tdata[LOSS_LO +: FRAC_W]),
    .link_cost_i   (s_axis_tdata[COST_LO +: DATA_W]),
    .reliability_i (s_axis_tdata[REL_LO +: FRAC_W]),
    .valid_o       (fr_valid),
    .divisor_o     (fr_divisor),
    .side_o        (fr_side)
  );

  lcm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (fr_valid),
    .divisor_i  (fr_divisor),
    .side_i     (fr_side),
    .valid_o    (dv_valid),
    .quotient_o (dv_quo),
    .side_o     (dv_side)
  );

  always_comb begin
    sat_d = dv_side.add_quo && dv_side.div_zero;
    if (sat_d) begin
      weight_d = WMAX;
    end else if (dv_side.add_quo) begin
      weight_d = dv_side.base + WEIGHT_W'(dv_quo);
    end else begin
      weight_d = dv_side.base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      weight_q <= weight_d;
      sat_q    <= sat_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_TDATA_W'(weight_q);
  assign m_axis_tuser  = sat_q;

`ifndef SYNTHESIS
  a_sat_gives_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[WEIGHT_W-1:0] == WMAX)
    else $error("saturated transaction without maximum weight");

  a_stall_only_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");
`endif

endmodule

>>> hdl/lcm_front.sv
module lcm_front
  import lcm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [STRAT_W-1:0] strat_i,
  input  logic [DATA_W-1:0]  latency_i,
  input  logic [DATA_W-1:0]  bandwidth_i,
  input  logic [FRAC_W-1:0]  utilization_i,
  input  logic [FRAC_W-1:0]  loss_frac_i,
  input  logic [DATA_W-1:0]  link_cost_i,
  input  logic [FRAC_W-1:0]  reliability_i,
  output logic               valid_o,
  output logic [DIV_W-1:0]   divisor_o,
  output div_side_t          side_o
);

  localparam int U5_W   = FRAC_W + 2;
  localparam int P10_W  = FRAC_W + 3;
  localparam int PEN_W  = FRAC_W + 3;
  localparam int RELW_W = FRAC_W + 7;
  localparam int USQ_W  = 2 * FRAC_W;
  localparam int CBP_W  = DATA_W + FRAC_W;
  localparam int K_W    = FRAC_W + 2;
  localparam int EFFP_W = DATA_W + K_W;
  localparam int COSTP_W = 2 * DATA_W;
  localparam int PENP_W = PEN_W - 1 + 32;
  localparam int EFFH_W = EFFP_W - FRAC_BITS - 1;
  localparam int COSTT_W = COSTP_W - MAG_SHIFT;
  localparam int PENQ_W = FRAC_W + 32;
  localparam int PENT_W = PENQ_W - MAG_SHIFT;

  localparam logic [U5_W-1:0]  U_LIMIT = {ONE_Q, 2'b00};
  localparam logic [P10_W-1:0] P_LIMIT = {3'b000, ONE_Q};

  function automatic logic [FRAC_W-1:0] clamp_frac(input logic [FRAC_W-1:0] v);
    return (v > ONE_Q) ? ONE_Q : v;
  endfunction

  // stage A: clamp, select mode, first products
  logic [FRAC_W-1:0] u_c, p_c, r_c;
  logic [U5_W-1:0]   u5_c;
  logic [P10_W-1:0]  p10_c;
  mode_e             mode_c;

  assign u_c   = clamp_frac(utilization_i);
  assign p_c   = clamp_frac(loss_frac_i);
  assign r_c   = clamp_frac(reliability_i);
  assign u5_c  = U5_W'(u_c) * U5_W'(5);
  assign p10_c = P10_W'(p_c) * P10_W'(10);

  always_comb begin
    case (strategy_e'(strat_i))
      STRAT_UNIFORM:   mode_c = MODE_UNIFORM;
      STRAT_LATENCY:   mode_c = MODE_LATENCY;
      STRAT_BALANCED:  mode_c = MODE_BALANCED;
      STRAT_BANDWIDTH: mode_c = MODE_INVBW;
      STRAT_COST:      mode_c = MODE_COST;
      STRAT_ADAPTIVE: begin
        if (u5_c > U_LIMIT) begin
          mode_c = MODE_RELIAB;
        end else if (p10_c > P_LIMIT) begin
          mode_c = MODE_INVBW;
        end else begin
          mode_c = MODE_BALANCED;
        end
      end
      default:         mode_c = MODE_LATENCY;
    endcase
  end

  logic                a_v_q;
  mode_e               a_mode_q;
  logic [DATA_W-1:0]   a_lat_q, a_bw_q, a_cost_q;
  logic [RELW_W-1:0]   a_relw_q;
  logic [USQ_W-1:0]    a_usq_q;
  logic [CBP_W-1:0]    a_cbp_q;
  logic [PEN_W-1:0]    a_pensum_q;

  // stage B: latency scaling, effective bandwidth, divisor, cost term
  logic [K_W-1:0]      k_c;
  logic [EFFP_W-1:0]   effp_c;
  logic [DATA_W-1:0]   cb_c;
  logic [DIV_W-1:0]    div_c;
  logic [DATA_W+1:0]   cost3_c;
  logic [COSTP_W-1:0]  costp_c;
  logic [PENP_W-1:0]   penp_c;

  assign k_c     = K_W'(ONE_Q) + K_W'(3) * K_W'(a_usq_q[USQ_W-1:FRAC_BITS]);
  assign effp_c  = EFFP_W'(a_lat_q) * EFFP_W'(k_c);
  assign cb_c    = a_cbp_q[FRAC_BITS +: DATA_W];
  assign div_c   = (a_mode_q == MODE_INVBW) ? DIV_W'(a_bw_q) : DIV_W'(cb_c) * DIV_W'(5);
  assign cost3_c = (DATA_W + 2)'(a_cost_q) * (DATA_W + 2)'(3);
  assign costp_c = COSTP_W'(cost3_c[DATA_W+1:2]) * COSTP_W'(MAG5);
  assign penp_c  = PENP_W'(a_pensum_q[PEN_W-1:1]) * PENP_W'(MAG5);

  logic                b_v_q;
  mode_e               b_mode_q;
  logic [DATA_W-1:0]   b_lat_q, b_cost_q;
  logic [RELW_W-1:0]   b_relw_q;
  logic [EFFP_W-1:0]   b_effp_q;
  logic [COSTP_W-1:0]  b_costp_q;
  logic [PENP_W-1:0]   b_penp_q;
  logic [DIV_W-1:0]    b_div_q;
  logic                b_dz_q;

  // stage C: penalty clamp and scale
  logic [FRAC_W-1:0]   pen_raw_c, pen_c;
  logic [FRAC_W+1:0]   pen3_c;
  logic [PENQ_W-1:0]   penq_c;

  assign pen_raw_c = b_penp_q[PENP_W-1:MAG_SHIFT];
  assign pen_c     = (pen_raw_c > ONE_Q) ? ONE_Q : pen_raw_c;
  assign pen3_c    = (FRAC_W + 2)'(pen_c) * (FRAC_W + 2)'(3);
  assign penq_c    = PENQ_W'(pen3_c[FRAC_W+1:2]) * PENQ_W'(MAG5);

  logic                c_v_q;
  mode_e               c_mode_q;
  logic [DATA_W-1:0]   c_lat_q, c_cost_q;
  logic [RELW_W-1:0]   c_relw_q;
  logic [EFFH_W-1:0]   c_effh_q;
  logic [COSTT_W-1:0]  c_cost_t_q;
  logic [PENQ_W-1:0]   c_penq_q;
  logic [DIV_W-1:0]    c_div_q;
  logic                c_dz_q;

  // stage D: base weight by mode
  logic [PENT_W-1:0]   pen_t_c;
  logic [WEIGHT_W-1:0] bal_c;
  div_side_t           side_c;

  assign pen_t_c = c_penq_q[PENQ_W-1:MAG_SHIFT];
  assign bal_c   = WEIGHT_W'(c_effh_q) + WEIGHT_W'(c_cost_t_q) + WEIGHT_W'(pen_t_c);

  always_comb begin
    side_c.add_quo  = (c_mode_q == MODE_INVBW) || (c_mode_q == MODE_BALANCED);
    side_c.div_zero = c_dz_q;
    case (c_mode_q)
      MODE_UNIFORM:  side_c.base = WEIGHT_W'(ONE_Q);
      MODE_LATENCY:  side_c.base = WEIGHT_W'(c_lat_q);
      MODE_COST:     side_c.base = WEIGHT_W'(c_cost_q);
      MODE_INVBW:    side_c.base = '0;
      MODE_BALANCED: side_c.base = bal_c;
      MODE_RELIAB:   side_c.base = WEIGHT_W'(c_relw_q);
      default:       side_c.base = WEIGHT_W'(c_lat_q);
    endcase
  end

  logic                d_v_q;
  logic [DIV_W-1:0]    d_div_q;
  div_side_t           d_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_mode_q   <= mode_c;
      a_lat_q    <= latency_i;
      a_bw_q     <= bandwidth_i;
      a_cost_q   <= link_cost_i;
      a_relw_q   <= RELW_W'(ONE_Q - r_c) * RELW_W'(100);
      a_usq_q    <= USQ_W'(u_c) * USQ_W'(u_c);
      a_cbp_q    <= CBP_W'(bandwidth_i) * CBP_W'(ONE_Q - p_c);
      a_pensum_q <= PEN_W'(p_c) * PEN_W'(7) + PEN_W'(u_c) * PEN_W'(3);

      b_mode_q   <= a_mode_q;
      b_lat_q    <= a_lat_q;
      b_cost_q   <= a_cost_q;
      b_relw_q   <= a_relw_q;
      b_effp_q   <= effp_c;
      b_costp_q  <= costp_c;
      b_penp_q   <= penp_c;
      b_div_q    <= div_c;
      b_dz_q     <= (div_c == '0);

      c_mode_q   <= b_mode_q;
      c_lat_q    <= b_lat_q;
      c_cost_q   <= b_cost_q;
      c_relw_q   <= b_relw_q;
      c_effh_q   <= b_effp_q[EFFP_W-1:FRAC_BITS+1];
      c_cost_t_q <= b_costp_q[COSTP_W-1:MAG_SHIFT];
      c_penq_q   <= penq_c;
      c_div_q    <= b_div_q;
      c_dz_q     <= b_dz_q;

      d_div_q    <= c_div_q;
      d_side_q   <= side_c;
    end
  end

  assign valid_o   = d_v_q;
  assign divisor_o = d_div_q;
  assign side_o    = d_side_q;

endmodule

>>> hdl/lcm_div.sv
module lcm_div
  import lcm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DIV_W-1:0]  divisor_i,
  input  div_side_t         side_i,
  output logic              valid_o,
  output logic [QUOT_W-1:0] quotient_o,
  output div_side_t         side_o
);

  // dividend is ONE*ONE; one restoring step per stage, MSB first
  localparam logic [QUOT_W-1:0] DIVIDEND = {1'b1, {(QUOT_W - 1){1'b0}}};
  localparam int LAST = QUOT_W - 1;

  logic              v_q    [QUOT_W];
  logic [DIV_W-1:0]  rem_q  [QUOT_W];
  logic [DIV_W-1:0]  dvs_q  [QUOT_W];
  logic [QUOT_W-1:0] quo_q  [QUOT_W];
  div_side_t         side_q [QUOT_W];

  logic [DIV_W-1:0]  rem_in [QUOT_W];
  logic [DIV_W-1:0]  dvs_in [QUOT_W];
  logic [QUOT_W-1:0] quo_in [QUOT_W];

  logic [DIV_W-1:0]  rem_d  [QUOT_W];
  logic [QUOT_W-1:0] quo_d  [QUOT_W];

  always_comb begin
    logic [DIV_W:0] trial;
    logic           ge;
    rem_in[0] = '0;
    dvs_in[0] = divisor_i;
    quo_in[0] = '0;
    for (int i = 1; i < QUOT_W; i++) begin
      rem_in[i] = rem_q[i-1];
      dvs_in[i] = dvs_q[i-1];
      quo_in[i] = quo_q[i-1];
    end
    for (int i = 0; i < QUOT_W; i++) begin
      trial    = {rem_in[i], DIVIDEND[LAST-i]};
      ge       = (trial >= {1'b0, dvs_in[i]});
      rem_d[i] = ge ? DIV_W'(trial - {1'b0, dvs_in[i]}) : trial[DIV_W-1:0];
      quo_d[i] = {quo_in[i][QUOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUOT_W; i++) begin
        v_q[i] <= 1'b0;
      end
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int i = 1; i < QUOT_W; i++) begin
        v_q[i] <= v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dvs_q[0]  <= divisor_i;
      side_q[0] <= side_i;
      for (int i = 0; i < QUOT_W; i++) begin
        rem_q[i] <= rem_d[i];
        quo_q[i] <= quo_d[i];
      end
      for (int i = 1; i < QUOT_W; i++) begin
        dvs_q[i]  <= dvs_q[i-1];
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign valid_o    = v_q[LAST];
  assign quotient_o = quo_q[LAST];
  assign side_o     = side_q[LAST];

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[LAST] && (dvs_q[LAST] != '0) |-> rem_q[LAST] < dvs_q[LAST])
    else $error("divider remainder not below divisor");

  a_quotient_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[LAST] && (dvs_q[LAST] != '0) |->
      (QUOT_W + DIV_W)'(quo_q[LAST]) * (QUOT_W + DIV_W)'(dvs_q[LAST])
        + (QUOT_W + DIV_W)'(rem_q[LAST]) == (QUOT_W + DIV_W)'(DIVIDEND))
    else $error("divider quotient and remainder do not rebuild dividend");
`endif

endmodule

>>> test/tb.sv
module tb;
  import lcm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [STRAT_W-1:0] STRAT_SPARE_LO = 3'd6;
  localparam logic [STRAT_W-1:0] STRAT_SPARE_HI = 3'd7;

  localparam longint unsigned ONE_L  = 64'd1 << FRAC_BITS;
  localparam longint unsigned WMAX_L = (64'd1 << WEIGHT_W) - 64'd1;

  localparam logic [FRAC_W-1:0] FRAC_MAX = '1;
  localparam logic [FRAC_W-1:0] U_HOT    = 17'd52429;  // just above 0.8
  localparam logic [FRAC_W-1:0] U_EDGE   = 17'd52428;  // just below 0.8
  localparam logic [FRAC_W-1:0] P_LOSSY  = 17'd6554;   // just above 0.1
  localparam logic [FRAC_W-1:0] P_EDGE   = 17'd6553;   // just below 0.1
  localparam logic [DATA_W-1:0] WORD_MAX = '1;

  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [DATA_W-1:0] latency;
    logic [DATA_W-1:0] bandwidth;
    logic [FRAC_W-1:0] util;
    logic [FRAC_W-1:0] loss;
    logic [DATA_W-1:0] cost;
    logic [FRAC_W-1:0] reliab;
  } link_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                saturated;
  } weight_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   cfg_we_i      = 1'b0;
  logic [STRAT_W-1:0]     cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;

  logic [STRAT_W-1:0] strat_cur = STRAT_LATENCY;
  weight_t            weight_q[$];
  bit                 quiet     = 1'b0;
  int                 hold_left = 0;
  int                 err_cnt   = 0;
  int                 links_sent  = 0;
  int                 weights_got = 0;
  int                 sat_got     = 0;
  bit [7:0]           strats_seen = '0;

  link_cost_metric u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  initial begin
    #3ms;
    $display("tb: errors");
    $finish;
  end

  function automatic longint unsigned clamp_frac(logic [FRAC_W-1:0] v);
    return (v > ONE_Q) ? ONE_L : longint'(v);
  endfunction

  function automatic longint unsigned clip_weight(longint unsigned w, inout bit sat);
    if (w > WMAX_L) begin
      sat = 1'b1;
      return WMAX_L;
    end
    return w;
  endfunction

  function automatic longint unsigned inv_bandwidth(longint unsigned bw, inout bit sat);
    if (bw == 0) begin
      sat = 1'b1;
      return WMAX_L;
    end
    return clip_weight((ONE_L * ONE_L) / bw, sat);
  endfunction

  function automatic longint unsigned mixed_weight(longint unsigned lat, longint unsigned bw,
                                                   longint unsigned u, longint unsigned p,
                                                   longint unsigned cost, inout bit sat);
    longint unsigned u2, eff, cb, pen, sum;
    u2  = (u * u) >> FRAC_BITS;
    eff = (lat * (ONE_L + 3 * u2)) >> FRAC_BITS;
    cb  = (bw * (ONE_L - p)) >> FRAC_BITS;
    pen = (7 * p + 3 * u) / 10;
    if (pen > ONE_L) pen = ONE_L;
    if (cb == 0) begin
      sat = 1'b1;
      return WMAX_L;
    end
    sum = (eff >> 1) + (ONE_L * ONE_L) / (5 * cb) + (3 * cost) / 20 + (3 * pen) / 20;
    return clip_weight(sum, sat);
  endfunction

  function automatic weight_t link_weight(link_t rec, logic [STRAT_W-1:0] strat);
    longint unsigned lat, bw, u, p, cost, r, w;
    bit      sat;
    weight_t res;
    lat  = rec.latency;
    bw   = rec.bandwidth;
    cost = rec.cost;
    u    = clamp_frac(rec.util);
    p    = clamp_frac(rec.loss);
    r    = clamp_frac(rec.reliab);
    sat  = 1'b0;
    case (strat)
      STRAT_UNIFORM:   w = ONE_L;
      STRAT_BALANCED:  w = mixed_weight(lat, bw, u, p, cost, sat);
      STRAT_BANDWIDTH: w = inv_bandwidth(bw, sat);
      STRAT_COST:      w = cost;
      STRAT_ADAPTIVE: begin
        if (5 * u > 4 * ONE_L) w = clip_weight((ONE_L - r) * 100, sat);
        else if (10 * p > ONE_L) w = inv_bandwidth(bw, sat);
        else w = mixed_weight(lat, bw, u, p, cost, sat);
      end
      default:         w = lat;
    endcase
    w = clip_weight(w, sat);
    res.weight    = w[WEIGHT_W-1:0];
    res.saturated = sat;
    return res;
  endfunction

  function automatic link_t mk_link(logic [DATA_W-1:0] lat, logic [DATA_W-1:0] bw,
                                    logic [FRAC_W-1:0] u, logic [FRAC_W-1:0] p,
                                    logic [DATA_W-1:0] cost, logic [FRAC_W-1:0] r);
    link_t rec;
    rec.latency   = lat;
    rec.bandwidth = bw;
    rec.util      = u;
    rec.loss      = p;
    rec.cost      = cost;
    rec.reliab    = r;
    return rec;
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return WORD_MAX;
      2:       return DATA_W'($urandom_range(255));
      3:       return DATA_W'($urandom_range(262144));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [FRAC_W-1:0] rand_frac();
    case ($urandom_range(9))
      0:       return '0;
      1:       return ONE_Q;
      2:       return FRAC_W'($urandom_range(131071));
      3:       return FRAC_W'($urandom_range(52426, 52431));
      4:       return FRAC_W'($urandom_range(6551, 6556));
      default: return FRAC_W'($urandom_range(65536));
    endcase
  endfunction

  function automatic link_t rand_link();
    return mk_link(rand_word(), rand_word(), rand_frac(), rand_frac(), rand_word(),
                   rand_frac());
  endfunction

  task automatic send_link(link_t rec);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[6*0+DATA_W*3+FRAC_W*3-1:0] = {rec.reliab, rec.cost, rec.loss, rec.util,
                                       rec.bandwidth, rec.latency};
    if (!quiet) begin
      while ($urandom_range(99) < 13) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    weight_q.push_back(link_weight(rec, strat_cur));
    links_sent++;
    strats_seen[strat_cur] = 1'b1;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (weight_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_strategy(logic [STRAT_W-1:0] strat);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= strat;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    strat_cur = strat;
  endtask

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk_i) begin
    weight_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      weights_got++;
      if (m_axis_tuser[0]) sat_got++;
      if (weight_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("tb: unexpected weight %h sat %b", m_axis_tdata[WEIGHT_W-1:0],
                   m_axis_tuser[0]);
      end else begin
        want = weight_q.pop_front();
        if (want.weight !== m_axis_tdata[WEIGHT_W-1:0] ||
            want.saturated !== m_axis_tuser[0]) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("tb: weight mismatch: want %h sat %b, got %h sat %b",
                     want.weight, want.saturated, m_axis_tdata[WEIGHT_W-1:0],
                     m_axis_tuser[0]);
        end
      end
    end
  end

  task automatic test_reset_strategy();
    send_link(mk_link(WORD_MAX, '0, FRAC_MAX, FRAC_MAX, WORD_MAX, FRAC_MAX));
    send_link(mk_link('0, WORD_MAX, '0, '0, '0, '0));
    send_link(rand_link());
  endtask

  task automatic test_adaptive_corners();
    set_strategy(STRAT_ADAPTIVE);
    send_link(mk_link('0, '0, U_HOT, '0, '0, '0));
    send_link(mk_link(WORD_MAX, '0, U_HOT, FRAC_MAX, WORD_MAX, FRAC_MAX));
    send_link(mk_link('0, '0, FRAC_MAX, '0, '0, 17'd1));
    send_link(mk_link(WORD_MAX, '0, U_EDGE, P_LOSSY, WORD_MAX, '0));
    send_link(mk_link('0, 32'd1, U_EDGE, P_LOSSY, '0, '0));
    send_link(mk_link(WORD_MAX, WORD_MAX, U_EDGE, P_EDGE, WORD_MAX, ONE_Q));
    send_link(mk_link(32'h0001_0000, '0, '0, '0, 32'h0002_0000, ONE_Q));
  endtask

  task automatic test_balanced_corners();
    set_strategy(STRAT_BALANCED);
    send_link(mk_link(WORD_MAX, WORD_MAX, ONE_Q, ONE_Q, WORD_MAX, '0));
    send_link(mk_link(32'h0001_0000, 32'h0001_0000, '0, FRAC_MAX, '0, '0));
    send_link(mk_link(WORD_MAX, WORD_MAX, ONE_Q, '0, WORD_MAX, '0));
    send_link(mk_link(WORD_MAX, 32'd1, FRAC_MAX, '0, WORD_MAX, FRAC_MAX));
    send_link(mk_link(32'h0003_8000, 32'h0064_0000, 17'h4000, 17'h0800, 32'h0000_C000,
                      17'hF000));
  endtask

  task automatic test_bandwidth_corners();
    set_strategy(STRAT_BANDWIDTH);
    send_link(mk_link(WORD_MAX, '0, '0, '0, WORD_MAX, '0));
    send_link(mk_link('0, 32'd1, '0, '0, '0, '0));
    send_link(mk_link('0, WORD_MAX, '0, '0, '0, '0));
    send_link(mk_link('0, 32'h0001_0000, FRAC_MAX, FRAC_MAX, '0, FRAC_MAX));
  endtask

  task automatic test_random_sweep();
    logic [STRAT_W-1:0] order[10];
    int                 i, k;
    order = '{STRAT_UNIFORM, STRAT_ADAPTIVE, STRAT_LATENCY, STRAT_BALANCED, STRAT_SPARE_HI,
              STRAT_BANDWIDTH, STRAT_COST, STRAT_SPARE_LO, STRAT_ADAPTIVE, STRAT_BALANCED};
    for (i = 0; i < 10; i++) begin
      set_strategy(order[i]);
      for (k = 0; k < 36; k++) send_link(rand_link());
    end
  endtask

  task automatic test_steady_stream();
    int k;
    set_strategy(STRAT_BALANCED);
    quiet = 1'b1;
    for (k = 0; k < 60; k++) send_link(rand_link());
    drain_results();
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    int k;
    set_strategy(STRAT_ADAPTIVE);
    hold_left = 150;
    for (k = 0; k < 80; k++) send_link(rand_link());
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_strategy();
    test_adaptive_corners();
    test_balanced_corners();
    test_bandwidth_corners();
    test_random_sweep();
    test_steady_stream();
    test_backpressure();
    drain_results();
    $display("tb: %0d link records scored, %0d weights returned (%0d saturated)",
             links_sent, weights_got, sat_got);
    $display("tb: strategy codes exercised (bit per code): %b, mismatches %0d",
             strats_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

>>> link_cost_metric.f
hdl/lcm_pkg.sv
hdl/lcm_front.sv
hdl/lcm_div.sv
hdl/link_cost_metric.sv
test/tb.sv
